@@ rtl/ctr_pkg.sv @@
// ----------------------------------------------------------------------------
// ctr_pkg: shared types and constants for the color temperature converter
// Word types, class flags, pipeline latencies and the fixed-point fit
// coefficients, worked out at elaboration from their decimal values.
// ----------------------------------------------------------------------------
package ctr_pkg;

  // default fraction bits of the scaled temperature t
  localparam int FRAC_BITS_DEF = 16;

  // queue depths between the parts
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  // latencies of the back-end units, in enabled cycles
  localparam int LOG2_LAT   = 25;
  localparam int LOGFIT_LAT = 2;
  localparam int POW_LAT    = 37;
  localparam int BACK_LAT   = 1 + LOG2_LAT + POW_LAT;

  // input word
  typedef struct packed {
    logic        action;
    logic [15:0] temperature;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_word_t;

  // breakpoint classification of t
  typedef struct packed {
    logic le66;
    logic ge66;
    logic le19;
  } cls_t;

  // decimal constants scaled by 1e10
  localparam logic [63:0] DEC_SCALE = 64'd10000000000;
  localparam logic [63:0] R_COEF_D  = 64'd3296987274460;
  localparam logic [63:0] R_EXP_D   = 64'd1332047592;
  localparam logic [63:0] G_LOG_A_D = 64'd994708025861;
  localparam logic [63:0] G_LOG_B_D = 64'd1611195681661;
  localparam logic [63:0] G_COEF_D  = 64'd2881221695283;
  localparam logic [63:0] G_EXP_D   = 64'd755148492;
  localparam logic [63:0] B_LOG_A_D = 64'd1385177312231;
  localparam logic [63:0] B_LOG_B_D = 64'd3050447927307;
  localparam logic [63:0] LN2_D     = 64'd6931471806;

  // decimal to fixed point with q fraction bits, rounded to nearest
  function automatic logic [63:0] dec_to_q(input logic [63:0] v, input int q);
    logic [63:0] ip;
    logic [63:0] rem;
    ip  = v / DEC_SCALE;
    rem = v % DEC_SCALE;
    return (ip << q) + (((rem << q) + DEC_SCALE / 2) / DEC_SCALE);
  endfunction

  localparam logic [63:0] LN2_Q24 = dec_to_q(LN2_D, 24);
  localparam logic [29:0] LN2_Q30 = 30'(dec_to_q(LN2_D, 30));

  // log fits: slope times ln 2, and offset, Q24
  localparam logic [30:0] G_K_Q = 31'((dec_to_q(G_LOG_A_D, 24) * LN2_Q24) >> 24);
  localparam logic [33:0] G_B_Q = 34'(dec_to_q(G_LOG_B_D, 24));
  localparam logic [30:0] B_K_Q = 31'((dec_to_q(B_LOG_A_D, 24) * LN2_Q24) >> 24);
  localparam logic [33:0] B_B_Q = 34'(dec_to_q(B_LOG_B_D, 24));

  // power fits: exponent and coefficient, Q24
  localparam logic [23:0] R_E_Q = 24'(dec_to_q(R_EXP_D, 24));
  localparam logic [32:0] R_C_Q = 33'(dec_to_q(R_COEF_D, 24));
  localparam logic [23:0] G_E_Q = 24'(dec_to_q(G_EXP_D, 24));
  localparam logic [32:0] G_C_Q = 33'(dec_to_q(G_COEF_D, 24));

endpackage

@@ rtl/ctr_fifo.sv @@
// ----------------------------------------------------------------------------
// ctr_fifo: small first-word-fall-through queue
// Register array with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module ctr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/ctr_front.sv @@
// ----------------------------------------------------------------------------
// ctr_front: temperature intake and scaling
// Turns kelvin or mireds into the scaled temperature t through a pipelined
// restoring divider, clamps t and classifies it against the breakpoints.
// ----------------------------------------------------------------------------
module ctr_front #(
  parameter int FRAC_BITS = ctr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  ctr_pkg::in_word_t     in_data,
  output logic                  mid_push,
  input  logic                  mid_full,
  output logic [FRAC_BITS+8:0]  mid_t,
  output ctr_pkg::cls_t         mid_cls
);

  import ctr_pkg::*;

  localparam int DW = FRAC_BITS + 16;
  localparam int TW = FRAC_BITS + 9;

  localparam logic [DW-1:0] MIRED_NUM = DW'(64'd10000 << FRAC_BITS);
  localparam logic [DW-1:0] LO_Q      = DW'(64'd10 << FRAC_BITS);
  localparam logic [DW-1:0] HI_Q      = DW'(64'd400 << FRAC_BITS);
  localparam logic [TW-1:0] T66       = TW'(64'd66 << FRAC_BITS);
  localparam logic [TW-1:0] T19       = TW'(64'd19 << FRAC_BITS);

  typedef struct packed {
    logic [15:0]   rem;
    logic [DW-1:0] dd;
    logic [DW-1:0] quo;
  } div_t;

  // one restoring division step
  function automatic div_t div_step(input div_t s, input logic [15:0] dv);
    div_t        o;
    logic [16:0] rs;
    rs = {s.rem, s.dd[DW-1]};
    o.dd = s.dd << 1;
    if (rs >= {1'b0, dv}) begin
      o.rem = 16'(rs - {1'b0, dv});
      o.quo = {s.quo[DW-2:0], 1'b1};
    end else begin
      o.rem = rs[15:0];
      o.quo = {s.quo[DW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic          vld_r [DW];
  div_t          st_r  [DW];
  logic [15:0]   dv_r  [DW];
  logic          zm_r  [DW];
  logic          en;
  logic [15:0]   kel;
  div_t          st0;
  logic [15:0]   dv0;
  logic [TW-1:0] t_val;

  assign en       = !(vld_r[DW-1] && mid_full);
  assign in_full  = !en;
  assign mid_push = vld_r[DW-1] && !mid_full;

  // operand preparation
  always_comb begin
    if (in_data.temperature < 16'd1000) begin
      kel = 16'd1000;
    end else if (in_data.temperature > 16'd40000) begin
      kel = 16'd40000;
    end else begin
      kel = in_data.temperature;
    end
    st0.rem = '0;
    st0.quo = '0;
    if (in_data.action) begin
      st0.dd = MIRED_NUM;
      dv0    = in_data.temperature;
    end else begin
      st0.dd = {kel, {FRAC_BITS{1'b0}}};
      dv0    = 16'd100;
    end
  end

  // valid bits of the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DW; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_push;
      for (int i = 1; i < DW; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // divider stages, one quotient bit each
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_step(st0, dv0);
      dv_r[0] <= dv0;
      zm_r[0] <= in_data.action && (in_data.temperature == '0);
      for (int i = 1; i < DW; i++) begin
        st_r[i] <= div_step(st_r[i-1], dv_r[i-1]);
        dv_r[i] <= dv_r[i-1];
        zm_r[i] <= zm_r[i-1];
      end
    end
  end

  // clamp and classify
  always_comb begin
    if (zm_r[DW-1] || st_r[DW-1].quo > HI_Q) begin
      t_val = TW'(HI_Q);
    end else if (st_r[DW-1].quo < LO_Q) begin
      t_val = TW'(LO_Q);
    end else begin
      t_val = TW'(st_r[DW-1].quo);
    end
    mid_cls.le66 = (t_val <= T66);
    mid_cls.ge66 = (t_val >= T66);
    mid_cls.le19 = (t_val <= T19);
  end

  assign mid_t = t_val;

endmodule

@@ rtl/ctr_log2.sv @@
// ----------------------------------------------------------------------------
// ctr_log2: pipelined base-2 logarithm
// Normalizes x to a Q30 mantissa, then squares it once per stage to give
// 24 fraction bits. Result is Q24 with a 4-bit integer part.
// ----------------------------------------------------------------------------
module ctr_log2 #(
  parameter int FRAC_BITS = ctr_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS+8:0] x,
  output logic [27:0]          l
);

  import ctr_pkg::*;

  localparam int XW = FRAC_BITS + 9;
  localparam int PW = $clog2(XW);
  localparam int NS = LOG2_LAT - 1;

  logic [30:0]    m_r  [LOG2_LAT];
  logic [3:0]     ip_r [LOG2_LAT];
  logic [23:0]    fr_r [LOG2_LAT];
  logic [PW-1:0]  msb;
  logic [XW+29:0] y;

  // leading one and normalizing shift
  always_comb begin
    msb = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        msb = PW'(i);
      end
    end
    y = {x, 30'b0} >> msb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= y[30:0];
      ip_r[0] <= 4'(32'(msb) - 32'(FRAC_BITS));
      fr_r[0] <= '0;
    end
  end

  // squaring stages, one fraction bit each
  for (genvar s = 1; s <= NS; s++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] hi;
    assign sq = m_r[s-1] * m_r[s-1];
    assign hi = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[s]  <= hi[31] ? hi[31:1] : hi[30:0];
        fr_r[s] <= {fr_r[s-1][22:0], hi[31]};
        ip_r[s] <= ip_r[s-1];
      end
    end
  end

  assign l = {ip_r[NS], fr_r[NS]};

endmodule

@@ rtl/ctr_logfit.sv @@
// ----------------------------------------------------------------------------
// ctr_logfit: logarithmic channel fit
// Channel = slope * ln(x) - offset, from log2(x), clamped to 0..255.
// ----------------------------------------------------------------------------
module ctr_logfit #(
  parameter logic [30:0] K_Q = ctr_pkg::G_K_Q,
  parameter logic [33:0] B_Q = ctr_pkg::G_B_Q
) (
  input  logic        clk,
  input  logic        en,
  input  logic [27:0] l,
  output logic [7:0]  res
);

  localparam logic [34:0] MAX_Q = 35'(64'd255 << 24);

  logic [58:0] kl_r;
  logic [7:0]  res_r;
  logic [34:0] a;
  logic [34:0] d;

  assign a = kl_r[58:24];
  assign d = a - 35'(B_Q);

  // product, then offset and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      kl_r <= K_Q * l;
      if (a < 35'(B_Q)) begin
        res_r <= 8'd0;
      end else if (d > MAX_Q) begin
        res_r <= 8'd255;
      end else begin
        res_r <= d[31:24];
      end
    end
  end

  assign res = res_r;

endmodule

@@ rtl/ctr_pow.sv @@
// ----------------------------------------------------------------------------
// ctr_pow: power channel fit
// Channel = coef * x^(-exp) via 2^z, z = -exp*log2(x). The fraction part of
// 2^z comes from a 16-term series, one multiply and one divide stage a term.
// ----------------------------------------------------------------------------
module ctr_pow #(
  parameter logic [23:0] EXP_Q  = ctr_pkg::R_E_Q,
  parameter logic [32:0] COEF_Q = ctr_pkg::R_C_Q
) (
  input  logic        clk,
  input  logic        en,
  input  logic [27:0] l,
  output logic [7:0]  res
);

  import ctr_pkg::*;

  localparam int NT = 16;
  localparam logic [34:0] MAX_Q = 35'(64'd255 << 24);

  logic [51:0] ul_r;
  logic [23:0] f_r;
  logic [5:0]  n2_r;
  logic        z2_r;
  logic [27:0] u;
  logic [28:0] uc;

  // series state after each term
  logic [29:0] zz_r   [NT+1];
  logic [5:0]  n_r    [NT+1];
  logic        z_r    [NT+1];
  logic [30:0] term_r [NT+1];
  logic [31:0] sum_r  [NT+1];
  // state between multiply and divide of a term
  logic [29:0] q_r    [1:NT];
  logic [29:0] azz_r  [1:NT];
  logic [5:0]  an_r   [1:NT];
  logic        az_r   [1:NT];
  logic [31:0] asum_r [1:NT];

  logic [64:0] v_r;
  logic        z4_r;
  logic [7:0]  res_r;
  logic [53:0] fz;
  logic [31:0] p;
  logic [34:0] vv;

  assign u  = ul_r[51:24];
  assign uc = {1'b0, u} + 29'h0FFFFFF;
  assign fz = f_r * LN2_Q30;
  assign p  = sum_r[NT] >> n_r[NT];
  assign vv = v_r[64:30];

  // exponent product, integer and fraction split, fraction times ln 2
  always_ff @(posedge clk) begin
    if (en) begin
      ul_r      <= EXP_Q * l;
      z2_r      <= (u == '0);
      n2_r      <= 6'(uc[28:24]);
      f_r       <= 24'(-u[23:0]);
      zz_r[0]   <= fz[53:24];
      n_r[0]    <= n2_r;
      z_r[0]    <= z2_r;
      term_r[0] <= 31'h40000000;
      sum_r[0]  <= 32'h40000000;
    end
  end

  // series terms
  for (genvar k = 1; k <= NT; k++) begin : g_term
    localparam logic [34:0] MK = 35'(((64'd1 << 34) + 64'(k) - 1) / 64'(k));
    logic [60:0] tp;
    logic [64:0] dp;
    assign tp = term_r[k-1] * zz_r[k-1];
    assign dp = q_r[k] * MK;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= tp[59:30];
        azz_r[k]  <= zz_r[k-1];
        an_r[k]   <= n_r[k-1];
        az_r[k]   <= z_r[k-1];
        asum_r[k] <= sum_r[k-1];
        term_r[k] <= {1'b0, dp[63:34]};
        sum_r[k]  <= asum_r[k] + {2'b0, dp[63:34]};
        zz_r[k]   <= azz_r[k];
        n_r[k]    <= an_r[k];
        z_r[k]    <= az_r[k];
      end
    end
  end

  // scale by the coefficient and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      v_r  <= COEF_Q * p;
      z4_r <= z_r[NT];
      if (z4_r || vv > MAX_Q) begin
        res_r <= 8'd255;
      end else begin
        res_r <= vv[31:24];
      end
    end
  end

  assign res = res_r;

endmodule

@@ rtl/ctr_back.sv @@
// ----------------------------------------------------------------------------
// ctr_back: channel evaluation
// Two log2 units feed the log and power fits; the breakpoint class picks
// each channel. All stages move together and stall when the last stage
// holds a result and the result queue is full.
// ----------------------------------------------------------------------------
module ctr_back #(
  parameter int FRAC_BITS = ctr_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  output logic                 mid_pop,
  input  logic [FRAC_BITS+8:0] mid_t,
  input  ctr_pkg::cls_t        mid_cls,
  output logic                 out_push,
  input  logic                 out_full,
  output ctr_pkg::out_word_t   out_word
);

  import ctr_pkg::*;

  localparam int TW = FRAC_BITS + 9;
  localparam int DL = POW_LAT - LOGFIT_LAT;

  localparam logic [TW-1:0] T60 = TW'(64'd60 << FRAC_BITS);
  localparam logic [TW-1:0] T10 = TW'(64'd10 << FRAC_BITS);

  logic          vld_r [BACK_LAT];
  cls_t          cls_r [BACK_LAT];
  logic [TW-1:0] x1_r;
  logic [TW-1:0] x2_r;
  logic          en;
  logic [27:0]   l1;
  logic [27:0]   l2;
  logic [7:0]    g_log;
  logic [7:0]    b_log;
  logic [7:0]    r_pow;
  logic [7:0]    g_pow;
  logic [7:0]    gd_r [DL];
  logic [7:0]    bd_r [DL];
  cls_t          cls_o;

  assign en       = !(vld_r[BACK_LAT-1] && out_full);
  assign mid_pop  = en && !mid_empty;
  assign out_push = vld_r[BACK_LAT-1] && !out_full;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BACK_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= !mid_empty;
      for (int i = 1; i < BACK_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // log arguments and class delay line
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r     <= mid_cls.le66 ? mid_t : mid_t - T60;
      x2_r     <= mid_t - T10;
      cls_r[0] <= mid_cls;
      for (int i = 1; i < BACK_LAT; i++) begin
        cls_r[i] <= cls_r[i-1];
      end
    end
  end

  ctr_log2 #(.FRAC_BITS(FRAC_BITS)) u_log2_a (.clk(clk), .en(en), .x(x1_r), .l(l1));
  ctr_log2 #(.FRAC_BITS(FRAC_BITS)) u_log2_b (.clk(clk), .en(en), .x(x2_r), .l(l2));

  ctr_logfit #(.K_Q(G_K_Q), .B_Q(G_B_Q)) u_gfit (.clk(clk), .en(en), .l(l1), .res(g_log));
  ctr_logfit #(.K_Q(B_K_Q), .B_Q(B_B_Q)) u_bfit (.clk(clk), .en(en), .l(l2), .res(b_log));

  ctr_pow #(.EXP_Q(R_E_Q), .COEF_Q(R_C_Q)) u_rpow (.clk(clk), .en(en), .l(l1), .res(r_pow));
  ctr_pow #(.EXP_Q(G_E_Q), .COEF_Q(G_C_Q)) u_gpow (.clk(clk), .en(en), .l(l1), .res(g_pow));

  // align log fit results with the power fits
  always_ff @(posedge clk) begin
    if (en) begin
      gd_r[0] <= g_log;
      bd_r[0] <= b_log;
      for (int i = 1; i < DL; i++) begin
        gd_r[i] <= gd_r[i-1];
        bd_r[i] <= bd_r[i-1];
      end
    end
  end

  // channel selection by breakpoint class
  always_comb begin
    cls_o = cls_r[BACK_LAT-1];
    out_word.red   = cls_o.le66 ? 8'd255 : r_pow;
    out_word.green = cls_o.le66 ? gd_r[DL-1] : g_pow;
    if (cls_o.ge66) begin
      out_word.blue = 8'd255;
    end else if (cls_o.le19) begin
      out_word.blue = 8'd0;
    end else begin
      out_word.blue = bd_r[DL-1];
    end
  end

endmodule

@@ rtl/color_temperature_to_rgb.sv @@
// ----------------------------------------------------------------------------
// color_temperature_to_rgb: color temperature to RGB converter
// Kelvin or mireds in, red/green/blue out, through piecewise log and power
// fits evaluated in fixed point.
//
//   channel  ports                       handshake      word
//   input    in_push in_full in_data     push / full    action, temperature
//   result   out_empty out_pop out_data  empty / pop    red, green, blue
//
// One word per cycle is accepted and delivered in steady state while out_pop is held high.
// The path runs through FRAC_BITS+16 divider stages, the middle queue,
// 63 back-end stages (25 for log2, 37 for the power fit) and the result
// queue. rst_n clears valid bits and queues only; no clearing pass.
// A full result queue stalls the back end, then the middle queue fills
// and the front end raises in_full.
// ----------------------------------------------------------------------------
module color_temperature_to_rgb #(
  parameter int FRAC_BITS = ctr_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ctr_pkg::in_word_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output ctr_pkg::out_word_t out_data
);

  import ctr_pkg::*;

  localparam int TW = FRAC_BITS + 9;
  localparam int MW = TW + $bits(cls_t);
  localparam int OW = $bits(out_word_t);

  logic          f_push;
  logic          m_full;
  logic [TW-1:0] f_t;
  cls_t          f_cls;
  logic          m_empty;
  logic          m_pop;
  logic [MW-1:0] m_rdata;
  logic          b_push;
  logic          o_full;
  out_word_t     b_word;
  logic [OW-1:0] o_rdata;

  // front end: scaling divider and classification
  ctr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .mid_push(f_push), .mid_full(m_full), .mid_t(f_t), .mid_cls(f_cls)
  );

  // queue between front and back
  ctr_fifo #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(f_push), .full(m_full), .wdata({f_t, f_cls}),
    .pop(m_pop), .empty(m_empty), .rdata(m_rdata)
  );

  // back end: fits and channel selection
  ctr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .mid_empty(m_empty), .mid_pop(m_pop),
    .mid_t(m_rdata[MW-1:$bits(cls_t)]), .mid_cls(cls_t'(m_rdata[$bits(cls_t)-1:0])),
    .out_push(b_push), .out_full(o_full), .out_word(b_word)
  );

  // result queue
  ctr_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(b_push), .full(o_full), .wdata(b_word),
    .pop(out_pop), .empty(out_empty), .rdata(o_rdata)
  );

  assign out_data = out_word_t'(o_rdata);

endmodule

@@ tb/sv/tb_color_temperature_to_rgb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_temperature_to_rgb: self-checking bench for the converter
// Sends kelvin and mired words through the input port, computes the expected
// red/green/blue in fixed point alongside, and compares every result word in
// order. Both sides insert random gaps; one phase runs with no gaps at all.
// ----------------------------------------------------------------------------
module tb_color_temperature_to_rgb;
  import ctr_pkg::*;

  localparam int FB          = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE_CYC  = 200;
  localparam logic UNIT_KELVIN = 1'b0;
  localparam logic UNIT_MIREDS = 1'b1;
  localparam longint ONE_Q24 = 64'sd1 << 24;
  localparam longint unsigned DEC_ONE = 64'd10000000000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_word_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_word_t out_data;

  out_word_t rgb_expected[$];
  int        mismatches;
  int        idle_cycles;
  int        send_gap_max;
  int        pop_gap_max;

  color_temperature_to_rgb DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  // clock
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // decimal scaled by 1e10 to fixed point, rounded to nearest
  function automatic longint unsigned fixed_of_decimal(longint unsigned v, int q);
    longint unsigned ip;
    longint unsigned rem;
    ip  = v / DEC_ONE;
    rem = v % DEC_ONE;
    return (ip << q) + (((rem << q) + DEC_ONE / 2) / DEC_ONE);
  endfunction

  // log2 of an FB-fraction value, signed Q24, by repeated squaring
  function automatic longint log2_fixed(longint unsigned x);
    int p;
    longint unsigned m;
    longint frac;
    frac = 0;
    if (x == 0) return 0;
    p = 63;
    while (x[p] == 1'b0) p--;
    if (p >= 30) m = x >> (p - 30);
    else m = x << (30 - p);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p - FB) * ONE_Q24 + frac;
  endfunction

  // 2^f for Q24 f in [0,1), Q30 result via truncated Taylor series
  function automatic longint unsigned exp2_fraction(longint unsigned f);
    longint unsigned z;
    longint unsigned sum;
    longint unsigned term;
    z = (f * fixed_of_decimal(64'd6931471806, 30)) >> 24;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * z) >> 30) / k;
      sum += term;
    end
    return sum;
  endfunction

  // clamp a Q24 channel to 0..255
  function automatic logic [7:0] channel_of_q24(longint v);
    if (v < 0) return 8'd0;
    if (v > 255 * ONE_Q24) return 8'd255;
    return 8'(v >>> 24);
  endfunction

  // a*ln(x) - b
  function automatic logic [7:0] log_curve(longint unsigned a, longint unsigned b,
                                           longint unsigned x);
    longint k;
    longint v;
    k = longint'((fixed_of_decimal(a, 24) * fixed_of_decimal(64'd6931471806, 24)) >> 24);
    v = (k * log2_fixed(x)) / ONE_Q24 - longint'(fixed_of_decimal(b, 24));
    return channel_of_q24(v);
  endfunction

  // c * x^(-e)
  function automatic logic [7:0] power_curve(longint unsigned c, longint unsigned e,
                                             longint unsigned x);
    longint z;
    longint unsigned u;
    longint unsigned n;
    longint unsigned f;
    longint unsigned p;
    longint unsigned v;
    z = -((longint'(fixed_of_decimal(e, 24)) * log2_fixed(x)) / ONE_Q24);
    if (z >= 0) return 8'd255;
    u = longint'(-z);
    n = (u + 64'd16777215) >> 24;
    f = n * 64'd16777216 - u;
    p = exp2_fraction(f);
    p = (n >= 63) ? 64'd0 : (p >> n);
    v = (fixed_of_decimal(c, 24) * p) >> 30;
    if (v > (64'd255 << 24)) return 8'd255;
    return 8'(v >> 24);
  endfunction

  // expected color of one input word
  function automatic out_word_t rgb_of_temperature(in_word_t w);
    longint unsigned t;
    longint unsigned kel;
    out_word_t o;
    if (w.action == UNIT_MIREDS) begin
      t = (w.temperature == 0) ? (64'd400 << FB)
                               : (64'd10000 << FB) / w.temperature;
    end else begin
      kel = w.temperature;
      if (kel < 1000) kel = 1000;
      if (kel > 40000) kel = 40000;
      t = (kel << FB) / 100;
    end
    if (t < (64'd10 << FB)) t = 64'd10 << FB;
    if (t > (64'd400 << FB)) t = 64'd400 << FB;
    if (t <= (64'd66 << FB)) begin
      o.red   = 8'd255;
      o.green = log_curve(64'd994708025861, 64'd1611195681661, t);
    end else begin
      o.red   = power_curve(64'd3296987274460, 64'd1332047592, t - (64'd60 << FB));
      o.green = power_curve(64'd2881221695283, 64'd755148492, t - (64'd60 << FB));
    end
    if (t >= (64'd66 << FB)) o.blue = 8'd255;
    else if (t <= (19 << FB)) o.blue = 8'd0;
    else o.blue = log_curve(64'd1385177312231, 64'd3050447927307, t - (64'd10 << FB));
    return o;
  endfunction

  task automatic report(string msg);
    $display("mismatch %s (time %0t)", msg, $time);
    mismatches++;
  endtask

  // send one word, with a random gap ahead of it
  task automatic send_word(logic unit, logic [15:0] value);
    int gap;
    in_word_t w;
    gap = $urandom_range(0, send_gap_max);
    w.action = unit;
    w.temperature = value;
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push = 1'b1;
    in_data = w;
    do @(posedge clk); while (in_full);
    rgb_expected.push_back(rgb_of_temperature(w));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_push = 1'b0;
    while (rgb_expected.size() != 0) @(negedge clk);
  endtask

  // result checking
  out_word_t head;
  always @(posedge clk) begin
    if (rst_n && !out_empty && out_pop) begin
      if (rgb_expected.size() == 0) begin
        report("unexpected result word");
      end else begin
        head = rgb_expected.pop_front();
        if (out_data.red != head.red)
          report($sformatf("red: got %0d expected %0d", out_data.red, head.red));
        if (out_data.green != head.green)
          report($sformatf("green: got %0d expected %0d", out_data.green, head.green));
        if (out_data.blue != head.blue)
          report($sformatf("blue: got %0d expected %0d", out_data.blue, head.blue));
      end
    end
  end

  // result side: random stalls before each pop
  initial begin
    int stall;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, pop_gap_max);
      if (stall > 0) begin
        out_pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_pop = 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // extremes, breakpoints and special cases
  task automatic test_directed();
    logic [15:0] kel[] = '{16'd0, 16'd999, 16'd1000, 16'd1001, 16'd1899, 16'd1900,
                           16'd1901, 16'd6599, 16'd6600, 16'd6601, 16'd40000,
                           16'd40001, 16'd65535};
    logic [15:0] mir[] = '{16'd0, 16'd1, 16'd25, 16'd26, 16'd151, 16'd152,
                           16'd526, 16'd527, 16'd1000, 16'd32768, 16'd65535};
    foreach (kel[i]) send_word(UNIT_KELVIN, kel[i]);
    foreach (mir[i]) send_word(UNIT_MIREDS, mir[i]);
  endtask

  // random kelvin, mostly the useful range
  task automatic test_random_kelvin(int n);
    for (int i = 0; i < n; i++)
      send_word(UNIT_KELVIN, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(900, 41000)));
  endtask

  // random mireds, mostly the useful range
  task automatic test_random_mireds(int n);
    for (int i = 0; i < n; i++)
      send_word(UNIT_MIREDS, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 1100)));
  endtask

  // back-to-back words with no gaps on either side
  task automatic test_full_rate(int n);
    send_gap_max = 0;
    pop_gap_max = 0;
    for (int i = 0; i < n; i++)
      send_word(logic'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    send_gap_max = 6;
    pop_gap_max = 6;
  endtask

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    send_gap_max = 6;
    pop_gap_max = 6;
    in_push = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_kelvin(200);
    wait_drained();
    test_random_mireds(200);
    test_full_rate(150);
    test_random_kelvin(50);
    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ctr_pkg.sv
rtl/ctr_fifo.sv
rtl/ctr_front.sv
rtl/ctr_log2.sv
rtl/ctr_logfit.sv
rtl/ctr_pow.sv
rtl/ctr_back.sv
rtl/color_temperature_to_rgb.sv
tb/sv/tb_color_temperature_to_rgb.sv
